// ----- sv/seep_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the two-wire serial eeprom slave
// no dependencies

package seep_pkg;

    localparam int MEMORY_BYTES = 256;
    localparam int COUNT_W      = 5;
    localparam int CLK_BIT      = 5;
    localparam int DAT_BIT      = 6;

    localparam logic [COUNT_W-1:0] CNT_LAST_BIT = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] CNT_ACK      = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] CNT_WORD_END = COUNT_W'(16);

    typedef enum logic [2:0] {
        PH_STANDBY = 3'd0,
        PH_DEVICE  = 3'd1,
        PH_WORD    = 3'd2,
        PH_READ    = 3'd3,
        PH_WRITE   = 3'd4
    } t_phase;

    typedef enum logic {
        STYLE_C01 = 1'b0,
        STYLE_C02 = 1'b1
    } t_style;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } t_mem_req;

endpackage

// ----- sv/seep_in_if.sv -----
`timescale 1ns / 1ps
// input channel: pin write or backdoor load transaction
// no dependencies

interface seep_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] port_byte;
    logic [7:0] load_address;
    logic [7:0] load_value;

    modport source (output valid, mode, port_byte, load_address, load_value, input ready);
    modport sink   (input valid, mode, port_byte, load_address, load_value, output ready);
endinterface

// ----- sv/seep_out_if.sv -----
`timescale 1ns / 1ps
// output channel: data-out bit and bus phase per transaction
// no dependencies

interface seep_out_if;
    logic       valid;
    logic       ready;
    logic       data_out;
    logic [2:0] phase;

    modport source (output valid, data_out, phase, input ready);
    modport sink   (input valid, data_out, phase, output ready);
endinterface

// ----- sv/seep_mem.sv -----
`timescale 1ns / 1ps
// eeprom byte store with per-entry valid bits and registered read
// depends on seep_pkg

module seep_mem #(
    parameter int MEMORY_BYTES = seep_pkg::MEMORY_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  seep_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    localparam int AW = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
    localparam logic [8:0] MB9 = 9'(MEMORY_BYTES);

    function automatic logic [AW-1:0] f_index(input logic [7:0] a);
        logic [8:0] ext;
        ext = {1'b0, a};
        if (ext >= MB9) begin
            ext = ext - MB9;
        end
        return ext[AW-1:0];
    endfunction

    logic [7:0]              r_mem [MEMORY_BYTES];
    logic [MEMORY_BYTES-1:0] r_valid;
    logic [7:0]              r_rdata;
    logic                    r_rvalid;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;

    assign waddr = f_index(i_req.waddr);
    assign raddr = f_index(i_req.raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata  <= r_mem[raddr];
            r_rvalid <= r_valid[raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'h00;

endmodule

// ----- sv/seep_ctrl.sv -----
`timescale 1ns / 1ps
// bus decoder: start/stop detection, bit shifting, phase sequencing, result register
// depends on seep_pkg, seep_in_if, seep_out_if

module seep_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_chip_style,
    seep_in_if.sink            i_in,
    seep_out_if.source         o_out,
    output seep_pkg::t_mem_req o_mem_req,
    input  logic [7:0]         i_mem_rdata
);

    localparam int CW = seep_pkg::COUNT_W;

    seep_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_control_shift, n_control_shift;
    logic [7:0]       r_word_pointer, n_word_pointer;
    logic [7:0]       r_byte_shift, n_byte_shift;
    logic             r_bs_mem, n_bs_mem;
    logic [CW-1:0]    r_bit_count, n_bit_count;
    logic             r_prev_data, n_prev_data;
    logic             r_prev_clock, n_prev_clock;
    logic             r_out_bit, n_out_bit;
    logic             r_o_valid, n_o_valid;
    logic             r_o_data, n_o_data;
    logic [2:0]       r_o_phase, n_o_phase;

    logic             accept;
    logic             scl;
    logic             sda;
    logic [7:0]       bs_eff;
    logic [CW-1:0]    cnt_inc;
    logic [7:0]       bs_wr;
    seep_pkg::t_mem_req mem_req;

    assign i_in.ready = !r_o_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign scl        = i_in.port_byte[seep_pkg::CLK_BIT];
    assign sda        = i_in.port_byte[seep_pkg::DAT_BIT];
    assign bs_eff     = r_bs_mem ? i_mem_rdata : r_byte_shift;
    assign cnt_inc    = r_bit_count + CW'(1);
    assign bs_wr      = {bs_eff[6:0], sda};

    always_comb begin
        n_phase         = r_phase;
        n_control_shift = r_control_shift;
        n_word_pointer  = r_word_pointer;
        n_byte_shift    = bs_eff;
        n_bs_mem        = 1'b0;
        n_bit_count     = r_bit_count;
        n_prev_data     = r_prev_data;
        n_prev_clock    = r_prev_clock;
        n_out_bit       = r_out_bit;
        mem_req         = '0;

        if (accept) begin
            if (i_in.mode) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = i_in.load_address;
                mem_req.wdata = i_in.load_value;
            end else begin
                if (r_prev_clock && scl) begin
                    if (r_prev_data && !sda) begin
                        n_phase         = seep_pkg::PH_DEVICE;
                        n_bit_count     = '0;
                        n_control_shift = '0;
                    end else if (!r_prev_data && sda) begin
                        n_phase = seep_pkg::PH_STANDBY;
                    end
                end else if (!r_prev_clock && scl) begin
                    unique case (r_phase)
                        seep_pkg::PH_DEVICE: begin
                            if (r_bit_count < seep_pkg::CNT_LAST_BIT) begin
                                n_control_shift = {r_control_shift[6:0], sda};
                            end else if (i_chip_style == seep_pkg::STYLE_C01) begin
                                n_word_pointer = r_control_shift;
                                n_phase = sda ? seep_pkg::PH_READ : seep_pkg::PH_WRITE;
                            end else begin
                                n_phase = sda ? seep_pkg::PH_READ : seep_pkg::PH_WORD;
                            end
                            n_bit_count = cnt_inc;
                        end
                        seep_pkg::PH_WORD: begin
                            if (i_chip_style == seep_pkg::STYLE_C02) begin
                                if (r_bit_count == seep_pkg::CNT_ACK) begin
                                    n_word_pointer = '0;
                                    n_out_bit      = 1'b0;
                                    n_bit_count    = cnt_inc;
                                end else begin
                                    n_word_pointer = {r_word_pointer[6:0], sda};
                                    if (r_bit_count == seep_pkg::CNT_WORD_END) begin
                                        n_bit_count = seep_pkg::CNT_ACK;
                                        n_phase     = seep_pkg::PH_WRITE;
                                    end else begin
                                        n_bit_count = cnt_inc;
                                    end
                                end
                            end
                        end
                        seep_pkg::PH_READ: begin
                            if (r_bit_count == seep_pkg::CNT_ACK) begin
                                n_out_bit     = 1'b0;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = r_word_pointer;
                                n_bs_mem      = 1'b1;
                                n_bit_count   = '0;
                            end else begin
                                n_out_bit    = bs_eff[7];
                                n_byte_shift = {bs_eff[6:0], 1'b0};
                                n_bit_count  = cnt_inc;
                                if (r_bit_count == seep_pkg::CNT_LAST_BIT) begin
                                    n_word_pointer = r_word_pointer + 8'd1;
                                end
                            end
                        end
                        seep_pkg::PH_WRITE: begin
                            if (r_bit_count == seep_pkg::CNT_ACK) begin
                                n_out_bit    = 1'b0;
                                n_byte_shift = '0;
                                n_bit_count  = '0;
                            end else begin
                                n_byte_shift = bs_wr;
                                n_bit_count  = cnt_inc;
                                if (r_bit_count == seep_pkg::CNT_LAST_BIT) begin
                                    mem_req.we     = 1'b1;
                                    mem_req.waddr  = r_word_pointer;
                                    mem_req.wdata  = bs_wr;
                                    n_word_pointer = r_word_pointer + 8'd1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                n_prev_data  = sda;
                n_prev_clock = scl;
            end
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        n_o_phase = r_o_phase;
        if (accept) begin
            n_o_valid = 1'b1;
            n_o_data  = n_out_bit;
            n_o_phase = n_phase;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= seep_pkg::PH_STANDBY;
            r_control_shift <= '0;
            r_word_pointer  <= '0;
            r_byte_shift    <= '0;
            r_bs_mem        <= 1'b0;
            r_bit_count     <= '0;
            r_prev_data     <= 1'b0;
            r_prev_clock    <= 1'b0;
            r_out_bit       <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_control_shift <= n_control_shift;
            r_word_pointer  <= n_word_pointer;
            r_byte_shift    <= n_byte_shift;
            r_bs_mem        <= n_bs_mem;
            r_bit_count     <= n_bit_count;
            r_prev_data     <= n_prev_data;
            r_prev_clock    <= n_prev_clock;
            r_out_bit       <= n_out_bit;
            r_o_valid       <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_data  <= n_o_data;
        r_o_phase <= n_o_phase;
    end

    assign o_mem_req      = mem_req;
    assign o_out.valid    = r_o_valid;
    assign o_out.data_out = r_o_data;
    assign o_out.phase    = r_o_phase;

    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in one transaction");

    a_read_in_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.re |-> (r_phase == seep_pkg::PH_READ && r_bit_count == seep_pkg::CNT_ACK))
        else $error("memory read outside read ack slot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= seep_pkg::CNT_WORD_END)
        else $error("bit count out of range");

    a_start_enters_device: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in.mode && r_prev_clock && scl && r_prev_data && !sda)
        |=> (r_phase == seep_pkg::PH_DEVICE && r_bit_count == '0))
        else $error("start condition did not restart the device phase");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready) |-> !i_in.ready)
        else $error("transaction accepted while result stalled");

endmodule

// ----- sv/serial_eeprom_two_wire_slave_core.sv -----
`timescale 1ns / 1ps
// result: registered, presented in the cycle after its transaction is accepted
// throughput: one transaction per cycle; the result register stalls input only
//   while a result waits unconsumed on the output channel
// reset: synchronous active low; bus state, counters and pin history clear,
//   chip_style returns to 24c02 style, and per-byte valid flags make every
//   memory byte read as zero until written, with no clearing pass
// top level of the two-wire serial eeprom slave; depends on seep_pkg,
// seep_in_if, seep_out_if, seep_mem, seep_ctrl

module serial_eeprom_two_wire_slave_core #(
    parameter int MEMORY_BYTES = seep_pkg::MEMORY_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    seep_in_if.sink    i_in,
    seep_out_if.source o_out
);

    logic               r_chip_style;
    seep_pkg::t_mem_req mem_req;
    logic [7:0]         mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_style <= seep_pkg::STYLE_C02;
        end else if (i_cfg_we) begin
            r_chip_style <= i_cfg_wdata;
        end
    end

    seep_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chip_style (r_chip_style),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    seep_mem #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- verif/serial_eeprom_two_wire_slave_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for serial_eeprom_two_wire_slave_core: bus pin writes and
// backdoor loads go in, the data-out bit and phase of each transaction are predicted
// depends on seep_pkg, seep_in_if, seep_out_if and the core

module serial_eeprom_two_wire_slave_core_tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 4;
    localparam int ITEM_TARGET  = 1800;
    localparam int QUIET_TAIL   = 250;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam int CFG_SPACING  = 350;

    typedef struct packed {
        logic             data_out;
        seep_pkg::t_phase phase;
    } t_pin_response;

    class eeprom_response_tracker;
        seep_pkg::t_style            style;
        seep_pkg::t_phase            phase;
        logic [7:0]                  ctrl_sr;
        logic [7:0]                  word_ptr;
        logic [7:0]                  data_sr;
        logic [seep_pkg::COUNT_W-1:0] bit_cnt;
        logic                        prev_sda;
        logic                        prev_scl;
        logic                        sda_out;
        logic [7:0]                  mem [seep_pkg::MEMORY_BYTES];
        t_pin_response               pending[$];
        int unsigned                 errors;

        function new();
            style    = seep_pkg::STYLE_C02;
            phase    = seep_pkg::PH_STANDBY;
            ctrl_sr  = '0;
            word_ptr = '0;
            data_sr  = '0;
            bit_cnt  = '0;
            prev_sda = 1'b0;
            prev_scl = 1'b0;
            sda_out  = 1'b0;
            errors   = 0;
            foreach (mem[i]) mem[i] = '0;
        endfunction

        function void set_style(bit v);
            style = seep_pkg::t_style'(v);
        endfunction

        function void shift_on_rise(logic sda);
            case (phase)
                seep_pkg::PH_DEVICE: begin
                    if (bit_cnt < seep_pkg::CNT_LAST_BIT) begin
                        ctrl_sr = {ctrl_sr[6:0], sda};
                    end else if (style == seep_pkg::STYLE_C01) begin
                        word_ptr = ctrl_sr;
                        phase    = sda ? seep_pkg::PH_READ : seep_pkg::PH_WRITE;
                    end else begin
                        phase = sda ? seep_pkg::PH_READ : seep_pkg::PH_WORD;
                    end
                    bit_cnt++;
                end
                seep_pkg::PH_WORD: begin
                    if (style == seep_pkg::STYLE_C02) begin
                        if (bit_cnt == seep_pkg::CNT_ACK) begin
                            word_ptr = '0;
                            sda_out  = 1'b0;
                        end else begin
                            word_ptr = {word_ptr[6:0], sda};
                            if (bit_cnt == seep_pkg::CNT_WORD_END) begin
                                bit_cnt = seep_pkg::CNT_LAST_BIT;
                                phase   = seep_pkg::PH_WRITE;
                            end
                        end
                        bit_cnt++;
                    end
                end
                seep_pkg::PH_READ: begin
                    if (bit_cnt == seep_pkg::CNT_ACK) begin
                        sda_out = 1'b0;
                        data_sr = mem[int'(word_ptr) % seep_pkg::MEMORY_BYTES];
                        bit_cnt = '0;
                    end else begin
                        sda_out = data_sr[7];
                        data_sr = {data_sr[6:0], 1'b0};
                        bit_cnt++;
                        if (bit_cnt == seep_pkg::CNT_ACK) word_ptr++;
                    end
                end
                seep_pkg::PH_WRITE: begin
                    if (bit_cnt == seep_pkg::CNT_ACK) begin
                        sda_out = 1'b0;
                        data_sr = '0;
                        bit_cnt = '0;
                    end else begin
                        data_sr = {data_sr[6:0], sda};
                        bit_cnt++;
                        if (bit_cnt == seep_pkg::CNT_ACK) begin
                            mem[int'(word_ptr) % seep_pkg::MEMORY_BYTES] = data_sr;
                            word_ptr++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_transaction(logic mode, logic [7:0] port, logic [7:0] addr,
                                       logic [7:0] val);
            logic scl;
            logic sda;
            scl = port[seep_pkg::CLK_BIT];
            sda = port[seep_pkg::DAT_BIT];
            if (mode) begin
                mem[int'(addr) % seep_pkg::MEMORY_BYTES] = val;
            end else begin
                if (prev_scl && scl) begin
                    // start / stop while the clock stays high
                    if (prev_sda && !sda) begin
                        phase   = seep_pkg::PH_DEVICE;
                        bit_cnt = '0;
                        ctrl_sr = '0;
                    end else if (!prev_sda && sda) begin
                        phase = seep_pkg::PH_STANDBY;
                    end
                end else if (!prev_scl && scl) begin
                    shift_on_rise(sda);
                end
                prev_sda = sda;
                prev_scl = scl;
            end
            pending.push_back('{data_out: sda_out, phase: phase});
        endfunction

        function void check_response(logic data_out, logic [2:0] phase_out);
            t_pin_response exp_rsp;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual data_out %0b phase %0d",
                         $time, data_out, phase_out);
                return;
            end
            exp_rsp = pending.pop_front();
            if (data_out !== exp_rsp.data_out) begin
                errors++;
                $display("%0t: data_out mismatch, expected %0b actual %0b",
                         $time, exp_rsp.data_out, data_out);
            end
            if (phase_out !== exp_rsp.phase) begin
                errors++;
                $display("%0t: phase mismatch, expected %0d actual %0d",
                         $time, exp_rsp.phase, phase_out);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    seep_in_if  in_ch ();
    seep_out_if out_ch ();

    eeprom_response_tracker tracker;
    int unsigned            items_sent;
    bit                     idling_on;
    bit                     long_hold_req;
    bit                     style_now;

    serial_eeprom_two_wire_slave_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic send_transaction(logic mode, logic [7:0] port, logic [7:0] addr,
                                    logic [7:0] val);
        int unsigned gap;
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.port_byte    <= port;
        in_ch.load_address <= addr;
        in_ch.load_value   <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.note_transaction(mode, port, addr, val);
        items_sent++;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pin(bit scl, bit sda);
        logic [7:0] port;
        port                     = 8'($urandom);
        port[seep_pkg::CLK_BIT]  = scl;
        port[seep_pkg::DAT_BIT]  = sda;
        send_transaction(1'b0, port, 8'($urandom), 8'($urandom));
    endtask

    task automatic backdoor(logic [7:0] addr, logic [7:0] val);
        send_transaction(1'b1, 8'($urandom), addr, val);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending.size() != 0);
    endtask

    task automatic cfg_write(bit v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        tracker.set_style(v);
        style_now = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic bus_start();
        pin(1'b0, 1'b1);
        pin(1'b1, 1'b1);
        pin(1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        pin(1'b0, 1'b0);
        pin(1'b1, 1'b0);
        pin(1'b1, 1'b1);
    endtask

    task automatic bus_bit(bit b);
        pin(1'b0, b);
        pin(1'b1, b);
        if ($urandom_range(0, 7) == 0) pin(1'b1, b);
    endtask

    task automatic bus_byte(logic [7:0] v, bit ack);
        for (int i = 7; i >= 0; i--) bus_bit(v[i]);
        bus_bit(ack);
    endtask

    task automatic write_sequence(bit style, logic [7:0] ptr, int unsigned n);
        bus_start();
        if (style == seep_pkg::STYLE_C01) begin
            bus_byte({ptr[6:0], 1'b0}, 1'b1);
        end else begin
            bus_byte({4'b1010, 3'($urandom), 1'b0}, 1'b1);
            bus_byte(ptr, 1'b1);
        end
        repeat (n) bus_byte(8'($urandom), 1'b1);
        bus_stop();
    endtask

    task automatic read_sequence(bit style, bit set_ptr, logic [7:0] ptr, int unsigned n);
        if (set_ptr && style == seep_pkg::STYLE_C02) begin
            bus_start();
            bus_byte({4'b1010, 3'($urandom), 1'b0}, 1'b1);
            bus_byte(ptr, 1'b1);
        end
        bus_start();
        if (style == seep_pkg::STYLE_C01) bus_byte({ptr[6:0], 1'b1}, 1'b1);
        else bus_byte({4'b1010, 3'($urandom), 1'b1}, 1'b1);
        for (int unsigned i = 0; i < n; i++) bus_byte(8'($urandom), i == n - 1);
        bus_stop();
    endtask

    function automatic logic [7:0] pick_ptr();
        if ($urandom_range(0, 3) == 0) return 8'hfc + 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    initial begin : response_sink
        int unsigned hold_left;
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                if (out_ch.valid && out_ch.ready)
                    tracker.check_response(out_ch.data_out, out_ch.phase);
                if (hold_left > 0) begin
                    hold_left--;
                    if (hold_left == 0) out_ch.ready <= 1'b1;
                end else if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    hold_left     = LONG_HOLD;
                    out_ch.ready <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    hold_left = $urandom_range(1, 17);
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned kind;
        int unsigned base;
        int unsigned next_cfg;
        bit          hold_done;
        bit          pause_done;
        tracker            = new();
        items_sent         = 0;
        idling_on          = 1'b1;
        long_hold_req      = 1'b0;
        style_now          = seep_pkg::STYLE_C02;
        hold_done          = 1'b0;
        pause_done         = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = 1'b0;
        in_ch.port_byte    = '0;
        in_ch.load_address = '0;
        in_ch.load_value   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: backdoor extremes, standby edges, wrapping write and read
        backdoor(8'hff, 8'hff);
        backdoor(8'h00, 8'h00);
        backdoor(8'h80, 8'ha5);
        cfg_write(seep_pkg::STYLE_C02);
        pin(1'b1, 1'b0);
        pin(1'b1, 1'b1);
        pin(1'b0, 1'b1);
        write_sequence(seep_pkg::STYLE_C02, 8'hfe, 3);
        read_sequence(seep_pkg::STYLE_C02, 1'b1, 8'hfe, 3);
        cfg_write(seep_pkg::STYLE_C01);
        write_sequence(seep_pkg::STYLE_C01, 8'h7f, 2);
        read_sequence(seep_pkg::STYLE_C01, 1'b0, 8'h7f, 2);
        // style switched while in the word address phase
        cfg_write(seep_pkg::STYLE_C02);
        bus_start();
        bus_byte(8'ha0, 1'b1);
        cfg_write(seep_pkg::STYLE_C01);
        bus_byte(8'h55, 1'b1);
        cfg_write(seep_pkg::STYLE_C02);
        bus_byte(8'h10, 1'b1);
        bus_byte(8'h3c, 1'b1);
        bus_stop();
        read_sequence(seep_pkg::STYLE_C02, 1'b1, 8'h10, 2);

        base     = 0;
        next_cfg = CFG_SPACING;
        while (items_sent - base < ITEM_TARGET) begin
            if (items_sent - base >= ITEM_TARGET - QUIET_TAIL) idling_on = 1'b0;
            if (!hold_done && items_sent - base >= 600) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            if (!pause_done && items_sent - base >= 1000) begin
                drain_results();
                pause_done = 1'b1;
            end
            if (items_sent - base >= next_cfg) begin
                cfg_write(($urandom_range(0, 2) != 0) ? !style_now : style_now);
                next_cfg += CFG_SPACING;
            end
            kind = $urandom_range(0, 15);
            if (kind <= 4) begin
                write_sequence(style_now, pick_ptr(), $urandom_range(0, 4));
            end else if (kind <= 8) begin
                read_sequence(style_now, 1'b0, pick_ptr(), $urandom_range(1, 4));
            end else if (kind <= 11) begin
                read_sequence(style_now, 1'b1, pick_ptr(), $urandom_range(1, 4));
            end else if (kind == 12) begin
                repeat ($urandom_range(4, 20)) pin(1'($urandom), 1'($urandom));
            end else if (kind == 13) begin
                // truncated transfer ended by a stop or a restart
                bus_start();
                repeat ($urandom_range(1, 12)) bus_bit(1'($urandom));
                if ($urandom_range(0, 1) == 0) bus_stop();
                else bus_start();
            end else begin
                repeat ($urandom_range(1, 4)) backdoor(8'($urandom), 8'($urandom));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
